[src/rab_pkg.sv]
package rab_pkg;

  localparam int CH_W = 8;
  localparam int LANES = 4;
  localparam int RGB_LANES = 3;
  localparam int ALPHA_LANE = 3;
  localparam int NUM_W = 25;
  localparam int DEN_W = 16;
  localparam int PROD_W = 16;
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = 2;

  localparam logic [2:0] OP_PA_NPA  = 3'd0;
  localparam logic [2:0] OP_PA_PA   = 3'd1;
  localparam logic [2:0] OP_NPA_NPA = 3'd2;
  localparam logic [2:0] OP_NPA_PA  = 3'd3;
  localparam logic [2:0] OP_TO_PA   = 3'd4;
  localparam logic [2:0] OP_TO_NPA  = 3'd5;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef logic [CH_W-1:0]   ch_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]  den_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [2:0]            op;
    ch_t [RGB_LANES-1:0]   src;
  } tag_t;

  typedef struct packed {
    num_t rem;
    den_t den;
    ch_t  quo;
    logic ovf;
  } dlane_t;

  typedef struct packed {
    dlane_t [LANES-1:0] lane;
    tag_t               tag;
  } dstage_t;

endpackage

[src/rab_in_if.sv]
interface rab_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, op, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, op, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

[src/rab_out_if.sv]
interface rab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

[src/rab_front.sv]
module rab_front (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [2:0]                               in_op,
  input  rab_pkg::ch_t [rab_pkg::LANES-1:0]        in_src,
  input  rab_pkg::ch_t [rab_pkg::LANES-1:0]        in_dst,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output rab_pkg::num_t [rab_pkg::LANES-1:0]       out_num,
  output rab_pkg::den_t [rab_pkg::LANES-1:0]       out_den,
  output rab_pkg::tag_t                            out_tag
);
  import rab_pkg::*;

  logic                     v1_r, v2_r;
  logic                     en1, en2;
  logic [2:0]               op1_r;
  ch_t [LANES-1:0]          s1_r, d1_r;
  prod_t                    pdi1_r, sa255_1_r;
  prod_t [RGB_LANES-1:0]    pdc1_r, psa1_r, p4_1_r;
  num_t [LANES-1:0]         num_nxt, num2_r;
  den_t [LANES-1:0]         den_nxt, den2_r;
  tag_t                     tag2_r;
  ch_t                      inv;
  num_t                     keep, add2;

  assign en2 = !v2_r || out_ready;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v2_r;
  assign out_num = num2_r;
  assign out_den = den2_r;
  assign out_tag = tag2_r;
  assign inv = CH_MAX - in_src[ALPHA_LANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      op1_r <= in_op;
      s1_r <= in_src;
      d1_r <= in_dst;
      pdi1_r <= PROD_W'(in_dst[ALPHA_LANE]) * PROD_W'(inv);
      sa255_1_r <= PROD_W'(in_src[ALPHA_LANE]) * PROD_W'(CH_MAX);
      for (int i = 0; i < RGB_LANES; i++) begin
        pdc1_r[i] <= PROD_W'(in_dst[i]) * PROD_W'(inv);
        psa1_r[i] <= PROD_W'(in_src[i]) * PROD_W'(in_src[ALPHA_LANE]);
        p4_1_r[i] <= PROD_W'(in_dst[i]) * (PROD_W'(in_dst[ALPHA_LANE]) + PROD_W'(1));
      end
    end
  end

  always_comb begin
    keep = '0;
    add2 = '0;
    for (int i = 0; i < RGB_LANES; i++) begin
      keep = NUM_W'(d1_r[i]) * NUM_W'(pdi1_r);
      add2 = NUM_W'(s1_r[i]) * (NUM_W'(sa255_1_r) + NUM_W'(1));
      case (op1_r)
        OP_PA_NPA: begin
          num_nxt[i] = NUM_W'(pdc1_r[i]) + NUM_W'(psa1_r[i]);
          den_nxt[i] = DEN_W'(CH_MAX);
        end
        OP_PA_PA: begin
          num_nxt[i] = NUM_W'(pdc1_r[i]);
          den_nxt[i] = DEN_W'(CH_MAX);
        end
        OP_NPA_NPA: begin
          num_nxt[i] = keep + add2;
          den_nxt[i] = pdi1_r + sa255_1_r + DEN_W'(1);
        end
        OP_NPA_PA: begin
          num_nxt[i] = keep + {1'b0, s1_r[i], 16'b0};
          den_nxt[i] = pdi1_r + sa255_1_r + DEN_W'(1);
        end
        OP_TO_PA: begin
          num_nxt[i] = NUM_W'(p4_1_r[i]);
          den_nxt[i] = DEN_W'(256);
        end
        OP_TO_NPA: begin
          num_nxt[i] = NUM_W'({d1_r[i], 8'b0});
          den_nxt[i] = DEN_W'(d1_r[ALPHA_LANE]) + DEN_W'(1);
        end
        default: begin
          num_nxt[i] = NUM_W'(d1_r[i]);
          den_nxt[i] = DEN_W'(1);
        end
      endcase
    end
    if (op1_r == OP_PA_NPA || op1_r == OP_PA_PA || op1_r == OP_NPA_NPA
        || op1_r == OP_NPA_PA) begin
      num_nxt[ALPHA_LANE] = NUM_W'(pdi1_r) + NUM_W'(sa255_1_r);
      den_nxt[ALPHA_LANE] = DEN_W'(CH_MAX);
    end else begin
      num_nxt[ALPHA_LANE] = NUM_W'(d1_r[ALPHA_LANE]);
      den_nxt[ALPHA_LANE] = DEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      num2_r <= num_nxt;
      den2_r <= den_nxt;
      tag2_r.op <= op1_r;
      tag2_r.src <= s1_r[RGB_LANES-1:0];
    end
  end

endmodule

[src/rab_div.sv]
module rab_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rab_pkg::num_t [rab_pkg::LANES-1:0] in_num,
  input  rab_pkg::den_t [rab_pkg::LANES-1:0] in_den,
  input  rab_pkg::tag_t                      in_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rab_pkg::ch_t [rab_pkg::LANES-1:0]  out_quo,
  output logic [rab_pkg::LANES-1:0]          out_ovf,
  output rab_pkg::tag_t                      out_tag
);
  import rab_pkg::*;

  logic [DIV_STAGES:0]   v_r;
  logic [DIV_STAGES+1:0] en;
  dstage_t               st_r   [DIV_STAGES+1];
  dstage_t               st_nxt [DIV_STAGES+1];
  num_t                  trial;
  int                    bitpos;

  always_comb begin
    en[DIV_STAGES+1] = out_ready;
    for (int k = DIV_STAGES; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[DIV_STAGES];
  assign out_tag = st_r[DIV_STAGES].tag;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = st_r[DIV_STAGES].lane[l].quo;
      out_ovf[l] = st_r[DIV_STAGES].lane[l].ovf;
    end
  end

  always_comb begin
    trial = '0;
    bitpos = 0;
    st_nxt[0].tag = in_tag;
    for (int l = 0; l < LANES; l++) begin
      st_nxt[0].lane[l].rem = in_num[l];
      st_nxt[0].lane[l].den = in_den[l];
      st_nxt[0].lane[l].quo = '0;
      st_nxt[0].lane[l].ovf = in_num[l] >= NUM_W'({in_den[l], 8'b0});
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          bitpos = CH_W - 1 - (k - 1) * BITS_PER_STAGE - b;
          trial = NUM_W'(st_nxt[k].lane[l].den) << bitpos;
          if (st_nxt[k].lane[l].rem >= trial) begin
            st_nxt[k].lane[l].rem = st_nxt[k].lane[l].rem - trial;
            st_nxt[k].lane[l].quo[bitpos] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) st_r[0] <= st_nxt[0];
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k] && v_r[k-1]) st_r[k] <= st_nxt[k];
    end
  end

endmodule

[src/rab_post.sv]
module rab_post (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rab_pkg::ch_t [rab_pkg::LANES-1:0]  in_quo,
  input  logic [rab_pkg::LANES-1:0]          in_ovf,
  input  rab_pkg::tag_t                      in_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rab_pkg::ch_t [rab_pkg::LANES-1:0]  out_pix
);
  import rab_pkg::*;

  logic            v_r;
  ch_t [LANES-1:0] pix_r, pix_nxt;
  logic [CH_W:0]   sum;

  assign in_ready = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_pix = pix_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (in_ovf[i]) begin
        pix_nxt[i] = CH_MAX;
      end else if (i < RGB_LANES && in_tag.op == OP_PA_PA) begin
        sum = {1'b0, in_quo[i]} + {1'b0, in_tag.src[i % RGB_LANES]};
        pix_nxt[i] = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
      end else begin
        pix_nxt[i] = in_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) pix_r <= pix_nxt;
  end

endmodule

[src/rgba_alpha_blend_unit.sv]
// Source-over alpha blending and alpha conversion for 8-bit RGBA pixels. One pixel
// beat is taken every clock unless the pipeline stalls. The front registers the
// products and then the numerators and divisors, the restoring divider registers
// an overflow check and then two quotient bits per stage, and a last register saturates
// and holds the result. Each stage stalls only when the stage after it is full.
module rgba_alpha_blend_unit (
  input  logic      clk,
  input  logic      rst_n,
  rab_in_if.sink    in_bus,
  rab_out_if.source out_bus
);
  import rab_pkg::*;

  ch_t [LANES-1:0]  src, dst, pix;
  num_t [LANES-1:0] f_num;
  den_t [LANES-1:0] f_den;
  tag_t             f_tag, d_tag;
  logic             f_valid, f_ready, d_valid, d_ready;
  ch_t [LANES-1:0]  d_quo;
  logic [LANES-1:0] d_ovf;

  assign src = {in_bus.src_alpha, in_bus.src_blue, in_bus.src_green, in_bus.src_red};
  assign dst = {in_bus.dst_alpha, in_bus.dst_blue, in_bus.dst_green, in_bus.dst_red};

  rab_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_bus.valid), .in_ready(in_bus.ready),
    .in_op(in_bus.op), .in_src(src), .in_dst(dst),
    .out_valid(f_valid), .out_ready(f_ready),
    .out_num(f_num), .out_den(f_den), .out_tag(f_tag)
  );

  rab_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(f_valid), .in_ready(f_ready),
    .in_num(f_num), .in_den(f_den), .in_tag(f_tag),
    .out_valid(d_valid), .out_ready(d_ready),
    .out_quo(d_quo), .out_ovf(d_ovf), .out_tag(d_tag)
  );

  rab_post u_post (
    .clk(clk), .rst_n(rst_n),
    .in_valid(d_valid), .in_ready(d_ready),
    .in_quo(d_quo), .in_ovf(d_ovf), .in_tag(d_tag),
    .out_valid(out_bus.valid), .out_ready(out_bus.ready),
    .out_pix(pix)
  );

  assign out_bus.out_red   = pix[0];
  assign out_bus.out_green = pix[1];
  assign out_bus.out_blue  = pix[2];
  assign out_bus.out_alpha = pix[3];

endmodule

[src/rab_check.sv]
module rab_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);
  logic [3:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, out_alpha}))
    else $error("Result beat changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 4'd0)
    else $error("Result beat without a pending input beat.");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 4'd8 |-> !in_ready || (out_valid && out_ready))
    else $error("More beats in flight than the pipeline holds.");

endmodule

bind rgba_alpha_blend_unit rab_check u_rab_check (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_red(out_bus.out_red),
  .out_green(out_bus.out_green),
  .out_blue(out_bus.out_blue),
  .out_alpha(out_bus.out_alpha)
);
